FILE: sv/prsched_pkg.sv
`default_nettype none
package prsched_pkg;

	// default sizes
	localparam int MAX_PROCS_DEF = 64;
	localparam int LEVELS_DEF    = 3;

	// fixed field widths
	localparam int KIND_W   = 1;
	localparam int TYPE_W   = 2;
	localparam int PRIO_W   = 2;
	localparam int TIME_W   = 16;
	localparam int IO_W     = 7;
	localparam int SHORT_W  = 3;
	localparam int SLICE_W  = 8;
	localparam int STATUS_W = 2;
	localparam int ID_W     = 6;
	localparam int CLK_W    = 32;
	localparam int POL_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// table entry: type, priority, remaining time, io chance
	localparam int ENTRY_W = TYPE_W + PRIO_W + TIME_W + IO_W;

	localparam logic [SHORT_W-1:0] SHORT_MAX      = 3'd4;
	localparam logic [SLICE_W-1:0] TIME_SLICE_RST = 8'd5;

	// kinds
	localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_STEP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DISP  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// policies
	localparam logic [POL_W-1:0] POL_RR   = 2'd0;
	localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
	localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic do_add;
		logic do_empty;
		logic sort_init;
		logic rd_i;
		logic ld_slot_i;
		logic ld_lowest;
		logic rd_j;
		logic ld_cand;
		logic cmp_j;
		logic sw1;
		logic sw2;
		logic ld_slot;
		logic exec;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic kind_step;
		logic none;
		logic sort_need;
		logic sort_multi;
		logic j_last;
		logic i_more;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/prsched_ram.sv
`default_nettype none
module prsched_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/prsched_ctrl.sv
`default_nettype none
module prsched_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  prsched_pkg::sts_t    sts,
	output prsched_pkg::cmd_t    cmd
);
	import prsched_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SINIT  = 4'd2;
	localparam logic [3:0] S_I0     = 4'd3;
	localparam logic [3:0] S_I1     = 4'd4;
	localparam logic [3:0] S_I2     = 4'd5;
	localparam logic [3:0] S_J0     = 4'd6;
	localparam logic [3:0] S_J1     = 4'd7;
	localparam logic [3:0] S_J2     = 4'd8;
	localparam logic [3:0] S_SW1    = 4'd9;
	localparam logic [3:0] S_SW2    = 4'd10;
	localparam logic [3:0] S_RD1    = 4'd11;
	localparam logic [3:0] S_RD2    = 4'd12;
	localparam logic [3:0] S_EXEC   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.kind_step) begin
					cmd.do_add = 1'b1;
					state_d    = S_DONE;
				end else if (sts.none) begin
					cmd.do_empty = 1'b1;
					state_d      = S_DONE;
				end else if (sts.sort_need) begin
					state_d = S_SINIT;
				end else begin
					state_d = S_RD1;
				end
			end
			S_SINIT: begin
				cmd.sort_init = 1'b1;
				state_d = sts.sort_multi ? S_I0 : S_RD1;
			end
			S_I0: begin
				cmd.rd_i = 1'b1;
				state_d  = S_I1;
			end
			S_I1: begin
				cmd.ld_slot_i = 1'b1;
				state_d       = S_I2;
			end
			S_I2: begin
				cmd.ld_lowest = 1'b1;
				state_d       = S_J0;
			end
			S_J0: begin
				cmd.rd_j = 1'b1;
				state_d  = S_J1;
			end
			S_J1: begin
				cmd.ld_cand = 1'b1;
				state_d     = S_J2;
			end
			S_J2: begin
				cmd.cmp_j = 1'b1;
				state_d   = sts.j_last ? S_SW1 : S_J0;
			end
			S_SW1: begin
				cmd.sw1 = 1'b1;
				state_d = S_SW2;
			end
			S_SW2: begin
				cmd.sw2 = 1'b1;
				state_d = sts.i_more ? S_I0 : S_RD1;
			end
			S_RD1: begin
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.ld_slot = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: sv/prsched_dp.sv
`default_nettype none
module prsched_dp #(
	parameter int MAX_PROCS = prsched_pkg::MAX_PROCS_DEF,
	parameter int LEVELS    = prsched_pkg::LEVELS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  prsched_pkg::cmd_t                     cmd,
	output prsched_pkg::sts_t                     sts,
	input  wire                                   cfg_valid,
	input  wire  [prsched_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [prsched_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire  [prsched_pkg::KIND_W-1:0]        kind,
	input  wire  [prsched_pkg::TYPE_W-1:0]        proc_type,
	input  wire  [prsched_pkg::PRIO_W-1:0]        priority_req,
	input  wire  [prsched_pkg::TIME_W-1:0]        time_needed,
	input  wire  [prsched_pkg::IO_W-1:0]          io_prob,
	input  wire  [prsched_pkg::IO_W-1:0]          draw_percent,
	input  wire  [prsched_pkg::SHORT_W-1:0]       draw_short,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [prsched_pkg::STATUS_W-1:0]      status,
	output logic [prsched_pkg::ID_W-1:0]          proc_id,
	output logic [prsched_pkg::TYPE_W-1:0]        out_type,
	output logic [prsched_pkg::PRIO_W-1:0]        out_priority,
	output logic [prsched_pkg::SLICE_W-1:0]       slice_used,
	output logic [prsched_pkg::TIME_W-1:0]        remaining,
	output logic                                  finished,
	output logic [prsched_pkg::CLK_W-1:0]         clock_now
);
	import prsched_pkg::*;

	localparam int SLOT_W = $clog2(MAX_PROCS);
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam int RING_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int RDEPTH = LEVELS * MAX_PROCS;
	localparam int RA_W   = $clog2(RDEPTH);

	// configuration
	logic [POL_W-1:0]   policy_q;
	logic [SLICE_W-1:0] slice_q;

	// control state
	logic [MAX_PROCS-1:0] valid_q;
	logic [SLOT_W-1:0]    head_q  [LEVELS];
	logic [CNT_W-1:0]     count_q [LEVELS];
	logic [CNT_W-1:0]     live_q;
	logic [CLK_W-1:0]     clock_q;
	logic                 pend_q;

	// latched item
	logic [KIND_W-1:0]  kind_q;
	logic [TYPE_W-1:0]  type_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [TIME_W-1:0]  need_q;
	logic [IO_W-1:0]    io_q;
	logic [IO_W-1:0]    draw_q;
	logic [SHORT_W-1:0] short_q;

	// sort and step work registers
	logic [CNT_W-1:0]  i_q, j_q, best_q;
	logic [TIME_W-1:0] lowest_q;
	logic [SLOT_W-1:0] slot_i_q, best_slot_q, cand_q, slot_q;

	// prepared result
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [TYPE_W-1:0]   res_type_q;
	logic [PRIO_W-1:0]   res_prio_q;
	logic [SLICE_W-1:0]  res_used_q;
	logic [TIME_W-1:0]   res_rem_q;
	logic                res_fin_q;
	logic [CLK_W-1:0]    res_clock_q;

	// memories
	logic              ring_we;
	logic [RA_W-1:0]   ring_waddr, ring_raddr;
	logic [SLOT_W-1:0] ring_wdata, ring_q;
	logic              tab_we;
	logic [SLOT_W-1:0] tab_waddr;
	logic [ENTRY_W-1:0] tab_wdata, tab_q;

	function automatic logic [SLOT_W-1:0] wrap(input logic [SLOT_W-1:0] h,
			input logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(k);
		if (s >= (CNT_W+1)'(MAX_PROCS)) begin
			s = s - (CNT_W+1)'(MAX_PROCS);
		end
		return SLOT_W'(s);
	endfunction

	function automatic logic [RA_W-1:0] base(input logic [RING_W-1:0] r);
		return RA_W'(r) * RA_W'(MAX_PROCS);
	endfunction

	// lowest free slot
	logic [SLOT_W-1:0] free_slot;
	logic              any_free;
	always_comb begin
		free_slot = '0;
		any_free  = 1'b0;
		for (int k = MAX_PROCS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_slot = SLOT_W'(k);
				any_free  = 1'b1;
			end
		end
	end

	// lowest non-empty ring
	logic [RING_W-1:0] r_sel;
	logic              none;
	always_comb begin
		r_sel = '0;
		none  = 1'b1;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (count_q[k] != '0) begin
				r_sel = RING_W'(k);
				none  = 1'b0;
			end
		end
	end

	logic              full;
	logic [PRIO_W-1:0] prio_sat;
	logic [RING_W-1:0] r_add;
	logic [CNT_W-1:0]  n_sel;
	assign full     = (live_q >= CNT_W'(MAX_PROCS)) || !any_free;
	assign prio_sat = (prio_q > PRIO_W'(LEVELS - 1)) ? PRIO_W'(LEVELS - 1) : prio_q;
	assign r_add    = (policy_q == POL_PRIO) ? RING_W'(prio_sat) : '0;
	assign n_sel    = count_q[r_sel];

	// slice arithmetic on the fetched entry
	logic [TYPE_W-1:0]  e_type;
	logic [PRIO_W-1:0]  e_prio;
	logic [TIME_W-1:0]  e_rem;
	logic [IO_W-1:0]    e_io;
	logic [SHORT_W-1:0] shrt;
	logic [SLICE_W-1:0] tslice, used;
	logic [TIME_W-1:0]  new_rem;
	logic               done;
	logic [CLK_W:0]     clk_sum;
	logic [CLK_W-1:0]   clk_new;
	assign {e_type, e_prio, e_rem, e_io} = tab_q;
	always_comb begin
		shrt   = (short_q > SHORT_MAX) ? SHORT_MAX : short_q;
		tslice = (draw_q > e_io) ? SLICE_W'(shrt) : slice_q;
		if (e_rem > TIME_W'(tslice)) begin
			used    = tslice;
			new_rem = e_rem - TIME_W'(tslice);
			done    = 1'b0;
		end else begin
			used    = SLICE_W'(e_rem);
			new_rem = '0;
			done    = 1'b1;
		end
		clk_sum = {1'b0, clock_q} + (CLK_W+1)'(used);
		clk_new = clk_sum[CLK_W] ? '1 : clk_sum[CLK_W-1:0];
	end

	// ring addressing
	logic [CNT_W-1:0]  rk;
	logic [RING_W-1:0] wr_ring;
	logic [CNT_W-1:0]  wk;
	logic              swap;
	assign swap = (best_q != i_q);
	always_comb begin
		rk = cmd.rd_j ? j_q : (cmd.rd_i ? i_q : '0);
		ring_raddr = base(r_sel) + RA_W'(wrap(head_q[r_sel], rk));
		wr_ring = cmd.do_add ? r_add : r_sel;
		wk = cmd.sw1 ? i_q : (cmd.sw2 ? best_q : count_q[wr_ring]);
		ring_waddr = base(wr_ring) + RA_W'(wrap(head_q[wr_ring], wk));
		ring_wdata = cmd.sw1 ? best_slot_q : (cmd.sw2 ? slot_i_q :
			(cmd.do_add ? free_slot : slot_q));
		ring_we = (cmd.do_add && !full) || ((cmd.sw1 || cmd.sw2) && swap) ||
			(cmd.exec && !done && policy_q != POL_SJF);
		tab_we    = (cmd.do_add && !full) || cmd.exec;
		tab_waddr = cmd.do_add ? free_slot : slot_q;
		tab_wdata = cmd.do_add ? {type_q, prio_sat, need_q, io_q} :
			{e_type, e_prio, new_rem, e_io};
	end

	prsched_ram #(.WIDTH(SLOT_W), .DEPTH(RDEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_q)
	);

	prsched_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (ring_q),
		.rdata (tab_q)
	);

	// status to controller
	always_comb begin
		sts.kind_step  = (kind_q == KIND_STEP);
		sts.none       = none;
		sts.sort_need  = (policy_q == POL_SJF) && pend_q;
		sts.sort_multi = (n_sel > CNT_W'(1));
		sts.j_last     = ((CNT_W+1)'(j_q) + 1'b1) >= (CNT_W+1)'(n_sel);
		sts.i_more     = ((CNT_W+1)'(i_q) + 2'd2) < (CNT_W+1)'(n_sel);
		sts.out_free   = !out_valid || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_RR;
			slice_q   <= TIME_SLICE_RST;
			valid_q   <= '0;
			live_q    <= '0;
			clock_q   <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k < LEVELS; k++) begin
				head_q[k]  <= '0;
				count_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_POLICY) begin
					policy_q <= cfg_data[POL_W-1:0];
				end else begin
					slice_q <= cfg_data[SLICE_W-1:0];
				end
			end
			if (cmd.do_add && !full) begin
				valid_q[free_slot] <= 1'b1;
				count_q[r_add]     <= count_q[r_add] + 1'b1;
				live_q             <= live_q + 1'b1;
				pend_q             <= 1'b1;
			end
			if (cmd.sort_init) begin
				pend_q <= 1'b0;
			end
			if (cmd.exec) begin
				clock_q <= clk_new;
				if (done) begin
					valid_q[slot_q] <= 1'b0;
					head_q[r_sel]   <= wrap(head_q[r_sel], CNT_W'(1));
					count_q[r_sel]  <= count_q[r_sel] - 1'b1;
					live_q          <= live_q - 1'b1;
				end else if (policy_q != POL_SJF) begin
					head_q[r_sel] <= wrap(head_q[r_sel], CNT_W'(1));
				end
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q  <= kind;
			type_q  <= proc_type;
			prio_q  <= priority_req;
			need_q  <= time_needed;
			io_q    <= io_prob;
			draw_q  <= draw_percent;
			short_q <= draw_short;
		end
		if (cmd.sort_init) begin
			i_q <= '0;
		end
		if (cmd.ld_slot_i) begin
			slot_i_q <= ring_q;
		end
		if (cmd.ld_lowest) begin
			lowest_q    <= e_rem;
			best_q      <= i_q;
			best_slot_q <= slot_i_q;
			j_q         <= i_q + 1'b1;
		end
		if (cmd.ld_cand) begin
			cand_q <= ring_q;
		end
		if (cmd.cmp_j) begin
			if (e_rem < lowest_q) begin
				lowest_q    <= e_rem;
				best_q      <= j_q;
				best_slot_q <= cand_q;
			end
			j_q <= j_q + 1'b1;
		end
		if (cmd.sw2) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.ld_slot) begin
			slot_q <= ring_q;
		end
		if (cmd.do_add) begin
			res_used_q  <= '0;
			res_fin_q   <= 1'b0;
			res_clock_q <= clock_q;
			if (full) begin
				res_status_q <= ST_FULL;
				res_id_q     <= '0;
				res_type_q   <= '0;
				res_prio_q   <= '0;
				res_rem_q    <= '0;
			end else begin
				res_status_q <= ST_ADDED;
				res_id_q     <= ID_W'(free_slot);
				res_type_q   <= type_q;
				res_prio_q   <= prio_sat;
				res_rem_q    <= need_q;
			end
		end
		if (cmd.do_empty) begin
			res_status_q <= ST_NONE;
			res_id_q     <= '0;
			res_type_q   <= '0;
			res_prio_q   <= '0;
			res_used_q   <= '0;
			res_rem_q    <= '0;
			res_fin_q    <= 1'b0;
			res_clock_q  <= clock_q;
		end
		if (cmd.exec) begin
			res_status_q <= ST_DISP;
			res_id_q     <= ID_W'(slot_q);
			res_type_q   <= e_type;
			res_prio_q   <= e_prio;
			res_used_q   <= used;
			res_rem_q    <= new_rem;
			res_fin_q    <= done;
			res_clock_q  <= clk_new;
		end
		if (cmd.load_out) begin
			status       <= res_status_q;
			proc_id      <= res_id_q;
			out_type     <= res_type_q;
			out_priority <= res_prio_q;
			slice_used   <= res_used_q;
			remaining    <= res_rem_q;
			finished     <= res_fin_q;
			clock_now    <= res_clock_q;
		end
	end
endmodule
`default_nettype wire

FILE: sv/process_scheduler_rr_sjf_priority_core.sv
// a shortest-first step after adds first sorts its ring of queued processes,
// each compare costing a ring read then a table read
// one item at a time: the next item is taken only once the last result is in the output register
// reset: asynchronous active low, clears valid bits, ring pointers, counts, clock and policy
`default_nettype none
module process_scheduler_rr_sjf_priority_core #(
	parameter int MAX_PROCS = prsched_pkg::MAX_PROCS_DEF,
	parameter int LEVELS    = prsched_pkg::LEVELS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [prsched_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [prsched_pkg::CFG_DATA_W-1:0]  cfg_data,
	// item channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [prsched_pkg::KIND_W-1:0]      kind,
	input  wire  [prsched_pkg::TYPE_W-1:0]      proc_type,
	input  wire  [prsched_pkg::PRIO_W-1:0]      priority_req,
	input  wire  [prsched_pkg::TIME_W-1:0]      time_needed,
	input  wire  [prsched_pkg::IO_W-1:0]        io_prob,
	input  wire  [prsched_pkg::IO_W-1:0]        draw_percent,
	input  wire  [prsched_pkg::SHORT_W-1:0]     draw_short,
	// result channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [prsched_pkg::STATUS_W-1:0]    status,
	output logic [prsched_pkg::ID_W-1:0]        proc_id,
	output logic [prsched_pkg::TYPE_W-1:0]      out_type,
	output logic [prsched_pkg::PRIO_W-1:0]      out_priority,
	output logic [prsched_pkg::SLICE_W-1:0]     slice_used,
	output logic [prsched_pkg::TIME_W-1:0]      remaining,
	output logic                                finished,
	output logic [prsched_pkg::CLK_W-1:0]       clock_now
);
	import prsched_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// the user must change registers only between items; the block does not enforce it, and a write beat is always taken
	assign cfg_ready = 1'b1;

	// sequencer: decode, optional selection sort, queue read-modify-write, result hand-off
	prsched_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// process table, order rings, pointers, clock and the output register
	prsched_dp #(.MAX_PROCS(MAX_PROCS), .LEVELS(LEVELS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.proc_type    (proc_type),
		.priority_req (priority_req),
		.time_needed  (time_needed),
		.io_prob      (io_prob),
		.draw_percent (draw_percent),
		.draw_short   (draw_short),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.proc_id      (proc_id),
		.out_type     (out_type),
		.out_priority (out_priority),
		.slice_used   (slice_used),
		.remaining    (remaining),
		.finished     (finished),
		.clock_now    (clock_now)
	);
endmodule
`default_nettype wire

FILE: sv/prsched_chk.sv
`default_nettype none
module prsched_chk (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire [prsched_pkg::STATUS_W-1:0]    status,
	input wire [prsched_pkg::ID_W-1:0]        proc_id,
	input wire [prsched_pkg::SLICE_W-1:0]     slice_used,
	input wire [prsched_pkg::TIME_W-1:0]      remaining,
	input wire                                finished
);
	import prsched_pkg::*;

	// one item in flight: an accepted beat blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a completed process has no time left and came from a dispatch
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> remaining == '0 && status == ST_DISP)
		else $error("finished beat inconsistent");

	// an add uses no ticks
	a_add: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> slice_used == '0 && !finished)
		else $error("add beat carries run data");

	// an empty step or a full add reports no process
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NONE || status == ST_FULL) |->
			proc_id == '0 && remaining == '0)
		else $error("empty or full beat carries process data");

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(remaining))
		else $error("stalled result changed");
endmodule

bind process_scheduler_rr_sjf_priority_core prsched_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.proc_id    (proc_id),
	.slice_used (slice_used),
	.remaining  (remaining),
	.finished   (finished)
);
`default_nettype wire
